[src/wheel_sync_pid_drive_core_assert.svh]
// Assertion macros shared by the drive core RTL.
// Each macro expands to one labeled concurrent assertion on clk, disabled
// while rst is high.
`ifndef WHEEL_SYNC_PID_DRIVE_CORE_ASSERT_SVH
`define WHEEL_SYNC_PID_DRIVE_CORE_ASSERT_SVH

// Same-cycle implication: when ante holds, cons holds at the same edge.
`define WSP_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication: when ante holds, cons holds at the next edge.
`define WSP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/wsp_pkg.sv]
// ----------------------------------------------------------------------------
// wsp_pkg
// Shared types and codes of the two-wheel drive core.
// ----------------------------------------------------------------------------
package wsp_pkg;

  localparam int REQ_W     = 3;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 16;
  localparam int DUTY_W    = 8;
  localparam int COUNT_W   = 32;
  localparam int ERR_W     = 33;
  localparam int ESUM_W    = 17;
  localparam int TARGET_W  = 24;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 40;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_LEFT_EDGE  = 3'd0;
  localparam logic [REQ_W-1:0] REQ_RIGHT_EDGE = 3'd1;
  localparam logic [REQ_W-1:0] REQ_FORWARD    = 3'd2;
  localparam logic [REQ_W-1:0] REQ_TURN_RIGHT = 3'd3;
  localparam logic [REQ_W-1:0] REQ_TURN_LEFT  = 3'd4;
  localparam logic [REQ_W-1:0] REQ_TICK       = 3'd5;

  // Motion modes
  localparam logic [1:0] MODE_IDLE  = 2'd0;
  localparam logic [1:0] MODE_FWD   = 2'd1;
  localparam logic [1:0] MODE_RIGHT = 2'd2;
  localparam logic [1:0] MODE_LEFT  = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P         = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I         = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D         = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INTEGRAL_LIMIT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CELL_TICKS     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_TURN = 3'd5;

  // PID gains and integral clamp
  typedef struct packed {
    logic signed [CFG_W-1:0] gain_p;
    logic signed [CFG_W-1:0] gain_i;
    logic signed [CFG_W-1:0] gain_d;
    logic        [CFG_W-1:0] integral_limit;
  } pid_cfg_t;

  // One PID update: new loop state and the two wheel duties
  typedef struct packed {
    logic signed [ESUM_W-1:0] error_sum;
    logic signed [ERR_W-1:0]  prior_error;
    logic        [DUTY_W-1:0] duty_left;
    logic        [DUTY_W-1:0] duty_right;
  } pid_res_t;

  // One result transaction
  typedef struct packed {
    logic [DUTY_W-1:0] chan_a1;
    logic [DUTY_W-1:0] chan_a2;
    logic [DUTY_W-1:0] chan_b1;
    logic [DUTY_W-1:0] chan_b2;
    logic              busy_res;
    logic              done_res;
  } result_t;

endpackage

[src/wsp_pid.sv]
// ----------------------------------------------------------------------------
// wsp_pid
// Wheel sync PID update: integral clamp, three Q8.8 products, half-correction
// truncated toward zero, and clamped left/right duties.
// ----------------------------------------------------------------------------
module wsp_pid (
  input  wsp_pkg::pid_cfg_t                    cfg,
  input  logic signed [wsp_pkg::COUNT_W-1:0]   left_count,
  input  logic signed [wsp_pkg::COUNT_W-1:0]   right_count,
  input  logic signed [wsp_pkg::ESUM_W-1:0]    error_sum,
  input  logic signed [wsp_pkg::ERR_W-1:0]     prior_error,
  input  logic        [wsp_pkg::DUTY_W-1:0]    held_speed,
  output wsp_pkg::pid_res_t                    res
);
  import wsp_pkg::*;

  logic signed [ERR_W-1:0] err;
  logic signed [33:0]      esum_raw;
  logic signed [33:0]      lim_pos;
  logic signed [33:0]      lim_neg;
  logic signed [33:0]      esum_clamped;
  logic signed [33:0]      deriv;
  logic signed [48:0]      p_prod;
  logic signed [32:0]      i_prod;
  logic signed [49:0]      d_prod;
  logic signed [51:0]      corr;
  logic signed [51:0]      corr_adj;
  logic signed [42:0]      half;
  logic signed [43:0]      base;
  logic signed [43:0]      left_raw;
  logic signed [43:0]      right_raw;

  function automatic logic [DUTY_W-1:0] sat_duty(input logic signed [43:0] v);
    logic [DUTY_W-1:0] r;
    if (v < 44'sd0) begin
      r = '0;
    end else if (v > 44'sd255) begin
      r = 8'd255;
    end else begin
      r = v[DUTY_W-1:0];
    end
    return r;
  endfunction

  // Count error and integral with symmetric clamp
  assign err      = $signed({left_count[COUNT_W-1], left_count})
                  - $signed({right_count[COUNT_W-1], right_count});
  assign esum_raw = $signed({{17{error_sum[ESUM_W-1]}}, error_sum})
                  + $signed({err[ERR_W-1], err});
  assign lim_pos  = $signed({18'd0, cfg.integral_limit});
  assign lim_neg  = -lim_pos;

  always_comb begin
    if (esum_raw < lim_neg) begin
      esum_clamped = lim_neg;
    end else if (esum_raw > lim_pos) begin
      esum_clamped = lim_pos;
    end else begin
      esum_clamped = esum_raw;
    end
  end

  assign deriv = $signed({err[ERR_W-1], err})
               - $signed({prior_error[ERR_W-1], prior_error});

  // Q8.8 products, one multiplier each
  assign p_prod = 49'(cfg.gain_p) * 49'(err);
  assign i_prod = 33'(cfg.gain_i) * 33'($signed(esum_clamped[ESUM_W-1:0]));
  assign d_prod = 50'(cfg.gain_d) * 50'(deriv);

  assign corr = 52'(p_prod) + 52'(i_prod) + 52'(d_prod);

  // corr / 512 toward zero: bias negatives before the arithmetic shift
  assign corr_adj = corr + (corr[51] ? 52'sd511 : 52'sd0);
  assign half     = $signed(corr_adj[51:9]);

  assign base      = $signed({36'd0, held_speed});
  assign left_raw  = base - 44'(half);
  assign right_raw = base + 44'(half);

  assign res.error_sum   = esum_clamped[ESUM_W-1:0];
  assign res.prior_error = err;
  assign res.duty_left   = sat_duty(left_raw);
  assign res.duty_right  = sat_duty(right_raw);

endmodule

[src/wsp_out_stage.sv]
// ----------------------------------------------------------------------------
// wsp_out_stage
// Result register on the master stream side; frees itself as the sink takes
// each transaction so a new result may load in the same cycle.
// ----------------------------------------------------------------------------
module wsp_out_stage (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              load,
  input  wsp_pkg::result_t                  result,
  output logic                              can_load,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // tdata: chan_a1[7:0], chan_a2[15:8], chan_b1[23:16], chan_b2[31:24],
  //        busy_res[32], done_res[33], zero fill [39:34]
  output logic [wsp_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);
  import wsp_pkg::*;

  logic                  out_valid;
  logic [OUT_DATA_W-1:0] out_data;

  assign can_load = !out_valid || m_axis_tready;

  // Valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (can_load) begin
      out_valid <= load;
    end
  end

  // Payload, first field in the low bits
  always_ff @(posedge clk) begin
    if (load && can_load) begin
      out_data <= {6'd0, result.done_res, result.busy_res, result.chan_b2,
                   result.chan_b1, result.chan_a2, result.chan_a1};
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

endmodule

[src/wheel_sync_pid_drive_core.sv]
// ----------------------------------------------------------------------------
// wheel_sync_pid_drive_core
// Two-wheel drive controller: encoder counting, PID wheel sync on forward
// moves, spot turns, four PWM duty channels.
// ----------------------------------------------------------------------------
// An input transaction passes the input register, then the result register,
// before its result can be accepted.
// Throughput: one transaction per cycle unless the result stream stalls; the
// state update and all three PID multipliers sit between the two registers.
// Reset (rst, synchronous): counts, PID state and duties clear, mode idle,
// configuration registers return to their defaults.
module wheel_sync_pid_drive_core (
  input  logic                               clk,
  input  logic                               rst,
  // Input stream
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // tdata: phase_b_low[0], cell_count[8:1], base_speed[16:9], zero fill [23:17]
  input  logic [wsp_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // tuser: req_type[2:0]
  input  logic [wsp_pkg::REQ_W-1:0]          s_axis_tuser,
  // Result stream
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // tdata: chan_a1[7:0], chan_a2[15:8], chan_b1[23:16], chan_b2[31:24],
  //        busy_res[32], done_res[33], zero fill [39:34]
  output logic [wsp_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  // Configuration write channel
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [wsp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [wsp_pkg::CFG_W-1:0]          cfg_data
);
  import wsp_pkg::*;

  // Configuration registers
  pid_cfg_t          pid_cfg;
  logic [CFG_W-1:0]  cell_ticks;
  logic [CFG_W-1:0]  ticks_per_turn;

  // Input register
  logic              in_valid;
  logic [REQ_W-1:0]  in_req;
  logic              in_up;
  logic [7:0]        in_cells;
  logic [7:0]        in_speed;

  // Controller state
  logic signed [COUNT_W-1:0] left_count,  left_count_next;
  logic signed [COUNT_W-1:0] right_count, right_count_next;
  logic signed [ESUM_W-1:0]  error_sum,   error_sum_next;
  logic signed [ERR_W-1:0]   prior_error, prior_error_next;
  logic [TARGET_W-1:0]       target_ticks, target_ticks_next;
  logic [1:0]                motion_mode, motion_mode_next;
  logic [DUTY_W-1:0]         held_speed,  held_speed_next;
  logic [DUTY_W-1:0]         duty_a1, duty_a1_next;
  logic [DUTY_W-1:0]         duty_a2, duty_a2_next;
  logic [DUTY_W-1:0]         duty_b1, duty_b1_next;
  logic [DUTY_W-1:0]         duty_b2, duty_b2_next;
  logic                      done_next;

  logic                      fire;
  logic                      can_load;
  logic signed [ERR_W-1:0]   move_sum;
  logic signed [ERR_W-1:0]   move_avg;
  logic                      reached;
  pid_res_t                  pid_res;
  result_t                   result;

  // Configuration writes, always accepted
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pid_cfg.gain_p         <= 16'sd256;
      pid_cfg.gain_i         <= 16'sd0;
      pid_cfg.gain_d         <= 16'sd0;
      pid_cfg.integral_limit <= 16'd1000;
      cell_ticks             <= 16'd512;
      ticks_per_turn         <= 16'd256;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_GAIN_P:         pid_cfg.gain_p         <= $signed(cfg_data);
        CFG_GAIN_I:         pid_cfg.gain_i         <= $signed(cfg_data);
        CFG_GAIN_D:         pid_cfg.gain_d         <= $signed(cfg_data);
        CFG_INTEGRAL_LIMIT: pid_cfg.integral_limit <= cfg_data;
        CFG_CELL_TICKS:     cell_ticks             <= cfg_data;
        CFG_TICKS_PER_TURN: ticks_per_turn         <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register handshake
  assign fire          = in_valid && can_load;
  assign s_axis_tready = !in_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_req   <= s_axis_tuser;
      in_up    <= s_axis_tdata[0];
      in_cells <= s_axis_tdata[8:1];
      in_speed <= s_axis_tdata[16:9];
    end
  end

  // Signed travel of the running move, halved toward zero
  always_comb begin
    case (motion_mode)
      MODE_FWD:   move_sum = $signed({left_count[COUNT_W-1], left_count})
                           + $signed({right_count[COUNT_W-1], right_count});
      MODE_RIGHT: move_sum = $signed({left_count[COUNT_W-1], left_count})
                           - $signed({right_count[COUNT_W-1], right_count});
      MODE_LEFT:  move_sum = $signed({right_count[COUNT_W-1], right_count})
                           - $signed({left_count[COUNT_W-1], left_count});
      default:    move_sum = '0;
    endcase
  end

  assign move_avg = (move_sum + $signed({32'd0, move_sum[ERR_W-1]})) >>> 1;
  assign reached  = move_avg >= $signed({9'd0, target_ticks});

  wsp_pid u_pid (
    .cfg         (pid_cfg),
    .left_count  (left_count),
    .right_count (right_count),
    .error_sum   (error_sum),
    .prior_error (prior_error),
    .held_speed  (held_speed),
    .res         (pid_res)
  );

  // Next state for the transaction in the input register
  always_comb begin
    left_count_next   = left_count;
    right_count_next  = right_count;
    error_sum_next    = error_sum;
    prior_error_next  = prior_error;
    target_ticks_next = target_ticks;
    motion_mode_next  = motion_mode;
    held_speed_next   = held_speed;
    duty_a1_next      = duty_a1;
    duty_a2_next      = duty_a2;
    duty_b1_next      = duty_b1;
    duty_b2_next      = duty_b2;
    done_next         = 1'b0;
    case (in_req)
      REQ_LEFT_EDGE: begin
        if (in_up && left_count != 32'sh7FFF_FFFF) begin
          left_count_next = left_count + 32'sd1;
        end else if (!in_up && left_count != $signed(32'h8000_0000)) begin
          left_count_next = left_count - 32'sd1;
        end
      end
      REQ_RIGHT_EDGE: begin
        if (in_up && right_count != 32'sh7FFF_FFFF) begin
          right_count_next = right_count + 32'sd1;
        end else if (!in_up && right_count != $signed(32'h8000_0000)) begin
          right_count_next = right_count - 32'sd1;
        end
      end
      REQ_FORWARD: begin
        left_count_next   = '0;
        right_count_next  = '0;
        error_sum_next    = '0;
        prior_error_next  = '0;
        target_ticks_next = 24'(in_cells) * 24'(cell_ticks);
        held_speed_next   = in_speed;
        motion_mode_next  = MODE_FWD;
      end
      REQ_TURN_RIGHT: begin
        left_count_next   = '0;
        right_count_next  = '0;
        target_ticks_next = 24'(ticks_per_turn);
        motion_mode_next  = MODE_RIGHT;
        duty_a1_next      = '0;
        duty_a2_next      = in_speed;
        duty_b1_next      = '0;
        duty_b2_next      = in_speed;
      end
      REQ_TURN_LEFT: begin
        left_count_next   = '0;
        right_count_next  = '0;
        target_ticks_next = 24'(ticks_per_turn);
        motion_mode_next  = MODE_LEFT;
        duty_a1_next      = in_speed;
        duty_a2_next      = '0;
        duty_b1_next      = in_speed;
        duty_b2_next      = '0;
      end
      REQ_TICK: begin
        if (motion_mode != MODE_IDLE) begin
          if (reached) begin
            duty_a1_next     = '0;
            duty_a2_next     = '0;
            duty_b1_next     = '0;
            duty_b2_next     = '0;
            motion_mode_next = MODE_IDLE;
            done_next        = 1'b1;
          end else if (motion_mode == MODE_FWD) begin
            error_sum_next   = pid_res.error_sum;
            prior_error_next = pid_res.prior_error;
            duty_a1_next     = '0;
            duty_a2_next     = pid_res.duty_left;
            duty_b1_next     = pid_res.duty_right;
            duty_b2_next     = '0;
          end
        end
      end
      default: ;
    endcase
  end

  // State update
  always_ff @(posedge clk) begin
    if (rst) begin
      left_count   <= '0;
      right_count  <= '0;
      error_sum    <= '0;
      prior_error  <= '0;
      target_ticks <= '0;
      motion_mode  <= MODE_IDLE;
      held_speed   <= '0;
      duty_a1      <= '0;
      duty_a2      <= '0;
      duty_b1      <= '0;
      duty_b2      <= '0;
    end else if (fire) begin
      left_count   <= left_count_next;
      right_count  <= right_count_next;
      error_sum    <= error_sum_next;
      prior_error  <= prior_error_next;
      target_ticks <= target_ticks_next;
      motion_mode  <= motion_mode_next;
      held_speed   <= held_speed_next;
      duty_a1      <= duty_a1_next;
      duty_a2      <= duty_a2_next;
      duty_b1      <= duty_b1_next;
      duty_b2      <= duty_b2_next;
    end
  end

  // Result transaction
  assign result.chan_a1  = duty_a1_next;
  assign result.chan_a2  = duty_a2_next;
  assign result.chan_b1  = duty_b1_next;
  assign result.chan_b2  = duty_b2_next;
  assign result.busy_res = motion_mode_next != MODE_IDLE;
  assign result.done_res = done_next;

  wsp_out_stage u_out (
    .clk           (clk),
    .rst           (rst),
    .load          (fire),
    .result        (result),
    .can_load      (can_load),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Checks
`include "wheel_sync_pid_drive_core_assert.svh"

  `WSP_ASSERT_NEXT(a_done_stops, fire && done_next, motion_mode == MODE_IDLE && duty_a1 == '0 && duty_a2 == '0 && duty_b1 == '0 && duty_b2 == '0, "finished move left motors running")
  `WSP_ASSERT_SAME(a_dir_split, 1'b1, !(duty_a1 != '0 && duty_a2 != '0) && !(duty_b1 != '0 && duty_b2 != '0), "both directions of one motor driven")
  `WSP_ASSERT_NEXT(a_isum_bound, fire && in_req == REQ_TICK && motion_mode == MODE_FWD && !reached, error_sum <= $signed({1'b0, pid_cfg.integral_limit}) && error_sum >= -$signed({1'b0, pid_cfg.integral_limit}), "integral outside clamp")
  `WSP_ASSERT_SAME(a_done_idle, m_axis_tvalid && m_axis_tdata[33], !m_axis_tdata[32], "done result reports busy")

endmodule

[test/wheel_sync_pid_drive_core_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// wheel_sync_pid_drive_core_checker
// Passive checker for the drive core. It follows the configuration writes
// and the input transactions, predicts the duties and flags of each result
// and compares every result transaction with the oldest prediction.
// ----------------------------------------------------------------------------
module wheel_sync_pid_drive_core_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  input  logic                           s_axis_tready,
  input  logic [wsp_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  input  logic [wsp_pkg::REQ_W-1:0]      s_axis_tuser,
  input  logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  input  logic [wsp_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [wsp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [wsp_pkg::CFG_W-1:0]      cfg_data,
  output int                             fail_count,
  output int                             pending,
  output int                             results_checked,
  output int                             moves_done,
  output logic                           move_busy
);
  import wsp_pkg::*;

  localparam longint COUNT_MAX  = 64'sd2147483647;
  localparam longint COUNT_MIN  = -64'sd2147483647 - 64'sd1;
  localparam longint DUTY_TOP   = 255;
  localparam int     REPORT_MAX = 10;

  // Configuration copy
  logic signed [CFG_W-1:0] kp, ki, kd;
  logic [CFG_W-1:0]        ilim, cell_ticks, turn_ticks;

  // Drive state
  longint               lcnt, rcnt, esum, perr;
  logic [TARGET_W-1:0]  tgt;
  logic [1:0]           mode;
  logic [DUTY_W-1:0]    hspd;
  logic [DUTY_W-1:0]    duty [4];

  result_t drive_expect_q [$];
  int nfail    = 0;
  int nchecked = 0;
  int ndone    = 0;

  function automatic longint clamp_l(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic void set_duty(logic [7:0] a1, logic [7:0] a2, logic [7:0] b1,
                                   logic [7:0] b2);
    duty[0] = a1;
    duty[1] = a2;
    duty[2] = b1;
    duty[3] = b2;
  endfunction

  function automatic void reset_drive();
    kp         = 16'sd256;
    ki         = '0;
    kd         = '0;
    ilim       = 16'd1000;
    cell_ticks = 16'd512;
    turn_ticks = 16'd256;
    lcnt = 0;
    rcnt = 0;
    esum = 0;
    perr = 0;
    tgt  = '0;
    mode = MODE_IDLE;
    hspd = '0;
    set_duty(8'd0, 8'd0, 8'd0, 8'd0);
  endfunction

  // One loop update of the wheel sync; duties go to the forward channels
  function automatic void pid_update();
    longint err, lim, der, corr, half, gp, gi, gd, ls, rs;
    err  = lcnt - rcnt;
    lim  = ilim;
    gp   = kp;
    gi   = ki;
    gd   = kd;
    esum = clamp_l(esum + err, -lim, lim);
    der  = err - perr;
    perr = err;
    corr = gp * err + gi * esum + gd * der;
    half = corr / 512;
    ls   = clamp_l(longint'(hspd) - half, 0, DUTY_TOP);
    rs   = clamp_l(longint'(hspd) + half, 0, DUTY_TOP);
    set_duty(8'd0, 8'(ls), 8'(rs), 8'd0);
  endfunction

  // Expected result of one input transaction; advances the drive state
  function automatic result_t predict_drive(logic [REQ_W-1:0] req, logic up,
                                            logic [7:0] cells, logic [7:0] speed);
    result_t r;
    logic    fin;
    longint  sum, avg, goal;
    fin = 1'b0;
    case (req)
      REQ_LEFT_EDGE:  lcnt = clamp_l(up ? lcnt + 1 : lcnt - 1, COUNT_MIN, COUNT_MAX);
      REQ_RIGHT_EDGE: rcnt = clamp_l(up ? rcnt + 1 : rcnt - 1, COUNT_MIN, COUNT_MAX);
      REQ_FORWARD: begin
        lcnt = 0;
        rcnt = 0;
        esum = 0;
        perr = 0;
        tgt  = cells * cell_ticks;
        hspd = speed;
        mode = MODE_FWD;
      end
      REQ_TURN_RIGHT: begin
        lcnt = 0;
        rcnt = 0;
        tgt  = turn_ticks;
        mode = MODE_RIGHT;
        set_duty(8'd0, speed, 8'd0, speed);
      end
      REQ_TURN_LEFT: begin
        lcnt = 0;
        rcnt = 0;
        tgt  = turn_ticks;
        mode = MODE_LEFT;
        set_duty(speed, 8'd0, speed, 8'd0);
      end
      REQ_TICK: begin
        if (mode != MODE_IDLE) begin
          if (mode == MODE_FWD) sum = lcnt + rcnt;
          else if (mode == MODE_RIGHT) sum = lcnt - rcnt;
          else sum = rcnt - lcnt;
          avg  = sum / 2;
          goal = tgt;
          if (avg >= goal) begin
            set_duty(8'd0, 8'd0, 8'd0, 8'd0);
            mode = MODE_IDLE;
            fin  = 1'b1;
            ndone++;
          end else if (mode == MODE_FWD) begin
            pid_update();
          end
        end
      end
      default: ;
    endcase
    r.chan_a1  = duty[0];
    r.chan_a2  = duty[1];
    r.chan_b1  = duty[2];
    r.chan_b2  = duty[3];
    r.busy_res = (mode != MODE_IDLE);
    r.done_res = fin;
    return r;
  endfunction

  function automatic void check_field(string fname, logic [7:0] exp_v, logic [7:0] got_v);
    if (exp_v !== got_v) begin
      if (nfail < REPORT_MAX)
        $display("%0t: result %0d %s mismatch: expected %0d, got %0d",
                 $realtime, nchecked, fname, exp_v, got_v);
      nfail++;
    end
  endfunction

  always @(posedge clk) begin : watch
    result_t got, exp_r;
    if (rst) begin
      reset_drive();
      drive_expect_q.delete();
    end else begin
      // Register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_GAIN_P:         kp = cfg_data;
          CFG_GAIN_I:         ki = cfg_data;
          CFG_GAIN_D:         kd = cfg_data;
          CFG_INTEGRAL_LIMIT: ilim = cfg_data;
          CFG_CELL_TICKS:     cell_ticks = cfg_data;
          CFG_TICKS_PER_TURN: turn_ticks = cfg_data;
          default: ;
        endcase
      end
      // Result transaction against the oldest prediction
      if (m_axis_tvalid && m_axis_tready) begin
        got.chan_a1  = m_axis_tdata[7:0];
        got.chan_a2  = m_axis_tdata[15:8];
        got.chan_b1  = m_axis_tdata[23:16];
        got.chan_b2  = m_axis_tdata[31:24];
        got.busy_res = m_axis_tdata[32];
        got.done_res = m_axis_tdata[33];
        if (drive_expect_q.size() == 0) begin
          if (nfail < REPORT_MAX)
            $display("%0t: result with nothing expected: tdata %h", $realtime, m_axis_tdata);
          nfail++;
        end else begin
          exp_r = drive_expect_q.pop_front();
          check_field("chan_a1", exp_r.chan_a1, got.chan_a1);
          check_field("chan_a2", exp_r.chan_a2, got.chan_a2);
          check_field("chan_b1", exp_r.chan_b1, got.chan_b1);
          check_field("chan_b2", exp_r.chan_b2, got.chan_b2);
          check_field("busy_res", 8'(exp_r.busy_res), 8'(got.busy_res));
          check_field("done_res", 8'(exp_r.done_res), 8'(got.done_res));
          nchecked++;
        end
      end
      // Input transaction
      if (s_axis_tvalid && s_axis_tready)
        drive_expect_q.push_back(predict_drive(s_axis_tuser, s_axis_tdata[0],
                                               s_axis_tdata[8:1], s_axis_tdata[16:9]));
    end
    fail_count      <= nfail;
    pending         <= drive_expect_q.size();
    results_checked <= nchecked;
    moves_done      <= ndone;
    move_busy       <= (mode != MODE_IDLE);
  end

endmodule

[test/wheel_sync_pid_drive_core_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// wheel_sync_pid_drive_core_tb
// Stimulus and verdict for the drive core. A directed run of edges, starts
// and ticks is followed by phases of random moves under several register
// settings and idle patterns, one of them with a long output hold-off.
// ----------------------------------------------------------------------------
module wheel_sync_pid_drive_core_tb;
  import wsp_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 300;

  // Codes with no function, sent to see that they change nothing
  localparam logic [REQ_W-1:0]     REQ_RESERVED_LO = 3'd6;
  localparam logic [REQ_W-1:0]     REQ_RESERVED_HI = 3'd7;
  localparam logic [CFG_IDX_W-1:0] CFG_RESERVED_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_RESERVED_HI = 3'd7;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic [REQ_W-1:0]      s_axis_tuser = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_W-1:0]      cfg_data = '0;

  int chk_fail, chk_pending, chk_results, chk_done;
  logic chk_busy;

  int tx_idle_pct  = 0;
  int rx_stall_pct = 0;
  int hold_seq     = 0;
  int hold_seen    = 0;
  int hold_left    = 0;
  int cycle_count  = 0;
  int items_sent   = 0;
  int cfg_writes   = 0;
  int phases       = 0;

  always #5 clk = ~clk;

  wheel_sync_pid_drive_core u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  wheel_sync_pid_drive_core_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .s_axis_tvalid   (s_axis_tvalid),
    .s_axis_tready   (s_axis_tready),
    .s_axis_tdata    (s_axis_tdata),
    .s_axis_tuser    (s_axis_tuser),
    .m_axis_tvalid   (m_axis_tvalid),
    .m_axis_tready   (m_axis_tready),
    .m_axis_tdata    (m_axis_tdata),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .fail_count      (chk_fail),
    .pending         (chk_pending),
    .results_checked (chk_results),
    .moves_done      (chk_done),
    .move_busy       (chk_busy)
  );

  // Result side: random stalls, or a long hold-off when one is requested
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (hold_seq != hold_seen) begin
      hold_seen     <= hold_seq;
      hold_left     <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count, chk_pending);
      $display("** wheel_sync_pid_drive_core: FAILED **");
      $finish;
    end
  end

  // One input transaction, after a random idle gap
  task automatic send_item(input logic [REQ_W-1:0] req, input logic phb,
                           input logic [7:0] cells, input logic [7:0] speed);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= req;
    s_axis_tdata  <= {7'd0, speed, cells, phb};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    items_sent++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_writes++;
  endtask

  task automatic set_config(input logic [15:0] kp, input logic [15:0] ki,
                            input logic [15:0] kd, input logic [15:0] lim,
                            input logic [15:0] cell_ticks, input logic [15:0] turn_ticks);
    write_reg(CFG_GAIN_P, kp);
    write_reg(CFG_GAIN_I, ki);
    write_reg(CFG_GAIN_D, kd);
    write_reg(CFG_INTEGRAL_LIMIT, lim);
    write_reg(CFG_CELL_TICKS, cell_ticks);
    write_reg(CFG_TICKS_PER_TURN, turn_ticks);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Mostly modest gains, sometimes any 16-bit value
  function automatic logic [15:0] pick_gain();
    int g;
    if ($urandom_range(3) == 0) return 16'($urandom);
    g = $urandom_range(0, 1024);
    return ($urandom_range(1) == 0) ? 16'(g) : 16'(-g);
  endfunction

  task automatic set_random_config(input int cell_hi, input int turn_hi);
    set_config(pick_gain(), pick_gain(), pick_gain(),
               ($urandom_range(1) == 0) ? 16'($urandom_range(0, 50)) : 16'($urandom),
               16'($urandom_range(1, cell_hi)), 16'($urandom_range(1, turn_hi)));
  endtask

  // Stop offering and wait until every result has come back
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    repeat (2) @(posedge clk);
    while (chk_pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    phases++;
  endtask

  // Random moves: a start, then edges biased toward progress, and ticks,
  // until the move finishes or the body budget runs out; some noise between
  task automatic run_moves(input int n_items, input int max_body);
    int          sent, steps, kind;
    logic [2:0]  req;
    logic [7:0]  cells;
    logic        want_l, want_r, wheel, good;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(99) < 12) begin
        send_item(3'($urandom_range(0, 7)), 1'($urandom), 8'($urandom), 8'($urandom));
        sent++;
      end else begin
        kind = $urandom_range(2);
        case (kind)
          0: begin req = REQ_FORWARD;    want_l = 1'b1; want_r = 1'b1; end
          1: begin req = REQ_TURN_RIGHT; want_l = 1'b1; want_r = 1'b0; end
          default: begin req = REQ_TURN_LEFT; want_l = 1'b0; want_r = 1'b1; end
        endcase
        cells = ($urandom_range(99) < 80) ? 8'($urandom_range(0, 4)) : 8'($urandom);
        send_item(req, 1'($urandom), cells, 8'($urandom));
        sent++;
        steps = 0;
        // move_busy lags by one transaction, so the first few steps ignore it
        while (steps < max_body && !(steps > 2 && !chk_busy)) begin
          kind = $urandom_range(99);
          if (kind < 30) begin
            send_item(REQ_TICK, 1'($urandom), 8'($urandom), 8'($urandom));
          end else if (kind < 32) begin
            steps = max_body;  // next start lands on a running move
          end else begin
            wheel = 1'($urandom);
            good  = wheel ? want_r : want_l;
            send_item(wheel ? REQ_RIGHT_EDGE : REQ_LEFT_EDGE,
                      ($urandom_range(99) < 85) ? good : !good, 8'($urandom), 8'($urandom));
          end
          sent++;
          steps++;
        end
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part: small targets so every path completes quickly
    set_config(16'd256, 16'd32, 16'hFFC0, 16'd5, 16'd2, 16'd1);
    send_item(REQ_TICK, 1'b1, 8'hFF, 8'hFF);          // tick while idle
    send_item(REQ_RESERVED_LO, 1'b1, 8'hFF, 8'hFF);
    send_item(REQ_RESERVED_HI, 1'b0, 8'h00, 8'h00);
    send_item(REQ_LEFT_EDGE, 1'b1, 8'h00, 8'h00);     // edges count while idle
    send_item(REQ_LEFT_EDGE, 1'b0, 8'hFF, 8'h00);
    send_item(REQ_RIGHT_EDGE, 1'b0, 8'h00, 8'hFF);
    send_item(REQ_FORWARD, 1'b0, 8'd1, 8'd128);       // duties hold until first tick
    send_item(REQ_TICK, 1'b0, 8'd0, 8'd0);
    repeat (3) send_item(REQ_LEFT_EDGE, 1'b1, 8'd0, 8'd0);
    send_item(REQ_TICK, 1'b0, 8'd0, 8'd0);            // correction from count error
    send_item(REQ_RIGHT_EDGE, 1'b0, 8'd0, 8'd0);
    send_item(REQ_TICK, 1'b0, 8'd0, 8'd0);
    repeat (2) send_item(REQ_RIGHT_EDGE, 1'b1, 8'd0, 8'd0);
    send_item(REQ_TICK, 1'b0, 8'd0, 8'd0);            // reaches target
    send_item(REQ_TICK, 1'b0, 8'd0, 8'd0);
    send_item(REQ_TURN_RIGHT, 1'b0, 8'd0, 8'd255);
    send_item(REQ_LEFT_EDGE, 1'b1, 8'd0, 8'd0);
    send_item(REQ_RIGHT_EDGE, 1'b0, 8'd0, 8'd0);
    send_item(REQ_TICK, 1'b0, 8'd0, 8'd0);
    send_item(REQ_TURN_LEFT, 1'b1, 8'd0, 8'd200);
    send_item(REQ_FORWARD, 1'b1, 8'd0, 8'd255);       // start while busy, zero target
    send_item(REQ_TICK, 1'b0, 8'd0, 8'd0);
    send_item(REQ_TURN_LEFT, 1'b0, 8'd0, 8'd0);
    send_item(REQ_TICK, 1'b0, 8'd0, 8'd0);
    drain();

    // Extreme gains, no integral room, smallest targets; no idling
    set_config(16'h7FFF, 16'h8000, 16'h7FFF, 16'd0, 16'd1, 16'd1);
    run_moves(130, 120);
    drain();

    // Opposite extreme gains, widest integral clamp; sender idles
    tx_idle_pct = 56;
    set_config(16'h8000, 16'h7FFF, 16'h8000, 16'hFFFF, 16'd3, 16'd5);
    run_moves(130, 120);
    drain();

    // Random settings; receiver stalls; reserved register indexes too
    tx_idle_pct  = 0;
    rx_stall_pct = 56;
    write_reg(CFG_RESERVED_LO, 16'($urandom));
    write_reg(CFG_RESERVED_HI, 16'($urandom));
    set_random_config(6, 12);
    run_moves(130, 120);
    drain();

    // Both sides idle
    tx_idle_pct  = 31;
    rx_stall_pct = 31;
    set_random_config(6, 12);
    run_moves(130, 120);
    drain();

    // Long output hold-off while the sender keeps offering
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    set_random_config(4, 8);
    hold_seq <= hold_seq + 1;
    run_moves(130, 120);
    drain();

    // Largest targets: moves run on until replaced
    tx_idle_pct  = 31;
    rx_stall_pct = 31;
    set_config(pick_gain(), pick_gain(), pick_gain(), 16'($urandom), 16'hFFFF, 16'hFFFF);
    run_moves(100, 40);
    drain();

    // Default gains and clamp with small targets
    tx_idle_pct  = 0;
    rx_stall_pct = 56;
    set_config(16'd256, 16'd0, 16'd0, 16'd1000, 16'd1, 16'd2);
    run_moves(100, 120);
    drain();

    $display("Covered %0d input transactions in %0d phases, %0d register writes;",
             items_sent, phases, cfg_writes);
    $display("%0d results checked, %0d moves or turns run to completion.",
             chk_results, chk_done);
    if (chk_fail == 0 && chk_pending == 0) begin
      $display("** wheel_sync_pid_drive_core: PASSED **");
    end else begin
      $display("%0d mismatches, %0d results outstanding", chk_fail, chk_pending);
      $display("** wheel_sync_pid_drive_core: FAILED **");
    end
    $finish;
  end

endmodule
